// File: design/ehx_pkg.sv
`default_nettype none
package ehx_pkg;

  // Offset counter width and its saturation value.
  localparam int OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  // Header offsets fit in seven bits. Every field, including the last L4 field, ends below 128.
  localparam int HDR_OFF_BITS = 7;

  // Result queue sizing: one byte produces at most two records.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;
  localparam int MAX_PUSH   = 2;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IHL_MIN    = 4'd5;
  localparam logic [HDR_OFF_BITS-1:0] IP_HDR_START  = 7'd14;
  localparam logic [HDR_OFF_BITS-1:0] IPV6_L4_START = 7'd54;

  localparam logic [15:0] PORT_DNS   = 16'd53;
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;

  localparam logic [19:0] FLOW_LABEL_MASK = 20'hFFFFF;

  typedef enum logic [1:0] {
    SVC_NONE  = 2'd0,
    SVC_DNS   = 2'd1,
    SVC_HTTP  = 2'd2,
    SVC_HTTPS = 2'd3
  } svc_t;

  typedef enum logic [1:0] {
    NET_OTHER = 2'd0,
    NET_IPV4  = 2'd1,
    NET_IPV6  = 2'd2,
    NET_ARP   = 2'd3
  } net_kind_t;

  typedef enum logic [1:0] {
    L4_NONE = 2'd0,
    L4_TCP  = 2'd1,
    L4_UDP  = 2'd2
  } l4_kind_t;

  typedef enum logic [5:0] {
    K_DST_MAC      = 6'd0,
    K_SRC_MAC      = 6'd1,
    K_ETHERTYPE    = 6'd2,
    K_IP4_HLEN     = 6'd3,
    K_IP4_TOTLEN   = 6'd4,
    K_IP4_ID       = 6'd5,
    K_IP4_FLAGS    = 6'd6,
    K_IP4_FRAGOFF  = 6'd7,
    K_IP4_TTL      = 6'd8,
    K_IP4_PROTO    = 6'd9,
    K_IP4_SRC      = 6'd10,
    K_IP4_DST      = 6'd11,
    K_IP6_TCLASS   = 6'd12,
    K_IP6_FLOW     = 6'd13,
    K_IP6_PAYLEN   = 6'd14,
    K_IP6_NXTHDR   = 6'd15,
    K_IP6_HOPLIM   = 6'd16,
    K_IP6_SRC_HI   = 6'd17,
    K_IP6_SRC_LO   = 6'd18,
    K_IP6_DST_HI   = 6'd19,
    K_IP6_DST_LO   = 6'd20,
    K_ARP_HTYPE    = 6'd21,
    K_ARP_PTYPE    = 6'd22,
    K_ARP_HLEN     = 6'd23,
    K_ARP_PLEN     = 6'd24,
    K_ARP_OPER     = 6'd25,
    K_ARP_SHA      = 6'd26,
    K_ARP_SPA      = 6'd27,
    K_ARP_THA      = 6'd28,
    K_ARP_TPA      = 6'd29,
    K_SRC_PORT     = 6'd30,
    K_DST_PORT     = 6'd31,
    K_TCP_SEQ      = 6'd32,
    K_TCP_ACK      = 6'd33,
    K_TCP_HLEN     = 6'd34,
    K_TCP_FLAGS    = 6'd35,
    K_TCP_WINDOW   = 6'd36,
    K_TCP_CSUM     = 6'd37,
    K_UDP_LEN      = 6'd38,
    K_UDP_CSUM     = 6'd39,
    K_FRAME_LEN    = 6'd40
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    svc_t        service;
    logic [31:0] packet_number;
    logic        last;
  } rec_t;

  function automatic svc_t svc_of(input logic [15:0] port);
    svc_t s;
    s = SVC_NONE;
    if (port == PORT_DNS) s = SVC_DNS;
    else if (port == PORT_HTTP) s = SVC_HTTP;
    else if (port == PORT_HTTPS) s = SVC_HTTPS;
    return s;
  endfunction

endpackage
`default_nettype wire

// File: design/eth_ip_l4_header_extractor.sv
`default_nettype none
// Channel  Handshake            Payload
// input    in_valid / in_stall  data_byte[7:0], last_byte
// output   out_valid/out_stall  record_kind[5:0], value[63:0], service[1:0],
//                               packet_number[31:0], last
//
// One frame byte is taken per cycle while in_stall is low. The byte is decoded in the same cycle
// against offset compares and lands as zero, one or two records in a
// four-word result queue. The queue head drives the output port.
// in_stall rises only when fewer than two queue slots are free, so a byte
// keeps flowing while earlier records wait on out_stall.
// Synchronous reset clears the parse state, the frame count and the queue.
module eth_ip_l4_header_extractor (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [7:0]           data_byte,
  input  wire                  last_byte,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [5:0]           record_kind,
  output logic [63:0]          value,
  output logic [1:0]           service,
  output logic [31:0]          packet_number,
  output logic                 last
);

  // Parse state
  logic [ehx_pkg::OFFSET_BITS-1:0]  byte_offset;
  logic [63:0]                      field_accumulator;
  ehx_pkg::net_kind_t               network_kind;
  ehx_pkg::l4_kind_t                transport_kind;
  logic [ehx_pkg::HDR_OFF_BITS-1:0] transport_start;
  logic [31:0]                      frame_count;

  logic [ehx_pkg::OFFSET_BITS-1:0]  byte_offset_next;
  logic [63:0]                      field_accumulator_next;
  ehx_pkg::net_kind_t               network_kind_next;
  ehx_pkg::l4_kind_t                transport_kind_next;
  logic [ehx_pkg::HDR_OFF_BITS-1:0] transport_start_next;
  logic [31:0]                      frame_count_next;

  // Result queue
  ehx_pkg::rec_t               fifo [ehx_pkg::FIFO_DEPTH];
  logic [ehx_pkg::FIFO_AW-1:0] rd_ptr;
  logic [ehx_pkg::FIFO_AW-1:0] wr_ptr;
  logic [ehx_pkg::FIFO_CW-1:0] count;

  logic                        accept;
  logic                        pop;
  logic [1:0]                  push_n;
  logic [ehx_pkg::FIFO_AW-1:0] len_ptr;

  // Byte decode
  logic                             hdr_in;
  logic [ehx_pkg::HDR_OFF_BITS-1:0] hdr_off;
  logic [ehx_pkg::HDR_OFF_BITS-1:0] rel;
  logic                             l4_on;
  logic [15:0]                      low2;
  logic                             fld_valid;
  ehx_pkg::rec_t                    fld_rec;
  ehx_pkg::rec_t                    len_rec;

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  // Hold the input whenever two records might not fit.
  assign in_stall = count > ehx_pkg::FIFO_CW'(ehx_pkg::FIFO_DEPTH - ehx_pkg::MAX_PUSH);

  // All defined fields sit below offset 128. Above that, only the length record matters.
  assign hdr_in  = byte_offset[ehx_pkg::OFFSET_BITS-1:ehx_pkg::HDR_OFF_BITS] == '0;
  assign hdr_off = byte_offset[ehx_pkg::HDR_OFF_BITS-1:0];
  assign rel     = hdr_off - transport_start;
  assign l4_on   = hdr_in && (transport_kind != ehx_pkg::L4_NONE)
                   && (transport_start != '0) && (hdr_off >= transport_start);

  assign field_accumulator_next = {field_accumulator[55:0], data_byte};
  assign low2                   = field_accumulator_next[15:0];
  // Bump the frame count on the first byte; records of that byte carry the new count.
  assign frame_count_next = (byte_offset == '0) ? frame_count + 32'd1 : frame_count;

  always_comb begin
    fld_valid                = 1'b0;
    fld_rec.kind             = ehx_pkg::K_DST_MAC;
    fld_rec.value            = '0;
    fld_rec.service          = ehx_pkg::SVC_NONE;
    fld_rec.packet_number    = frame_count_next;
    fld_rec.last             = 1'b0;
    network_kind_next        = network_kind;
    transport_kind_next      = transport_kind;
    transport_start_next     = transport_start;

    if (hdr_in) begin
      // Ethernet header
      case (hdr_off)
        7'd5: begin
          fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_DST_MAC;
          fld_rec.value = 64'(field_accumulator_next[47:0]);
        end
        7'd11: begin
          fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_SRC_MAC;
          fld_rec.value = 64'(field_accumulator_next[47:0]);
        end
        7'd13: begin
          fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ETHERTYPE;
          fld_rec.value = 64'(low2);
          case (low2)
            ehx_pkg::ETYPE_IPV4: network_kind_next = ehx_pkg::NET_IPV4;
            ehx_pkg::ETYPE_IPV6: network_kind_next = ehx_pkg::NET_IPV6;
            ehx_pkg::ETYPE_ARP:  network_kind_next = ehx_pkg::NET_ARP;
            default:             network_kind_next = ehx_pkg::NET_OTHER;
          endcase
        end
        default: ;
      endcase

      // Network header, chosen by the EtherType seen at offset 13
      case (network_kind)
        ehx_pkg::NET_IPV4: begin
          case (hdr_off)
            7'd14: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_HLEN;
              fld_rec.value = 64'({data_byte[3:0], 2'b00});
              // Drop L4 parsing when IHL is malformed.
              transport_start_next = (data_byte[3:0] >= ehx_pkg::IHL_MIN)
                ? ehx_pkg::IP_HDR_START + ehx_pkg::HDR_OFF_BITS'({data_byte[3:0], 2'b00})
                : '0;
            end
            7'd17: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_TOTLEN;
              fld_rec.value = 64'(low2);
            end
            7'd19: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_ID;
              fld_rec.value = 64'(low2);
            end
            7'd20: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_FLAGS;
              fld_rec.value = 64'(data_byte[7:5]);
            end
            7'd21: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_FRAGOFF;
              fld_rec.value = 64'(low2[12:0]);
            end
            7'd22: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_TTL;
              fld_rec.value = 64'(data_byte);
            end
            7'd23: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_PROTO;
              fld_rec.value = 64'(data_byte);
              if (transport_start != '0) begin
                if (data_byte == ehx_pkg::PROTO_TCP) transport_kind_next = ehx_pkg::L4_TCP;
                else if (data_byte == ehx_pkg::PROTO_UDP) transport_kind_next = ehx_pkg::L4_UDP;
                else transport_kind_next = ehx_pkg::L4_NONE;
              end
            end
            7'd29: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_SRC;
              fld_rec.value = 64'(field_accumulator_next[31:0]);
            end
            7'd33: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP4_DST;
              fld_rec.value = 64'(field_accumulator_next[31:0]);
            end
            default: ;
          endcase
        end
        ehx_pkg::NET_IPV6: begin
          case (hdr_off)
            7'd15: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_TCLASS;
              fld_rec.value = 64'(low2[11:4]);
            end
            7'd17: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_FLOW;
              fld_rec.value = 64'(field_accumulator_next[19:0] & ehx_pkg::FLOW_LABEL_MASK);
            end
            7'd19: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_PAYLEN;
              fld_rec.value = 64'(low2);
            end
            7'd20: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_NXTHDR;
              fld_rec.value = 64'(data_byte);
              // Fixed 40-byte header: L4 starts right after it.
              transport_start_next = ehx_pkg::IPV6_L4_START;
              if (data_byte == ehx_pkg::PROTO_TCP) transport_kind_next = ehx_pkg::L4_TCP;
              else if (data_byte == ehx_pkg::PROTO_UDP) transport_kind_next = ehx_pkg::L4_UDP;
              else transport_kind_next = ehx_pkg::L4_NONE;
            end
            7'd21: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_HOPLIM;
              fld_rec.value = 64'(data_byte);
            end
            7'd29: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_SRC_HI;
              fld_rec.value = field_accumulator_next;
            end
            7'd37: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_SRC_LO;
              fld_rec.value = field_accumulator_next;
            end
            7'd45: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_DST_HI;
              fld_rec.value = field_accumulator_next;
            end
            7'd53: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_IP6_DST_LO;
              fld_rec.value = field_accumulator_next;
            end
            default: ;
          endcase
        end
        ehx_pkg::NET_ARP: begin
          case (hdr_off)
            7'd15: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_HTYPE;
              fld_rec.value = 64'(low2);
            end
            7'd17: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_PTYPE;
              fld_rec.value = 64'(low2);
            end
            7'd18: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_HLEN;
              fld_rec.value = 64'(data_byte);
            end
            7'd19: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_PLEN;
              fld_rec.value = 64'(data_byte);
            end
            7'd21: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_OPER;
              fld_rec.value = 64'(low2);
            end
            7'd27: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_SHA;
              fld_rec.value = 64'(field_accumulator_next[47:0]);
            end
            7'd31: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_SPA;
              fld_rec.value = 64'(field_accumulator_next[31:0]);
            end
            7'd37: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_THA;
              fld_rec.value = 64'(field_accumulator_next[47:0]);
            end
            7'd41: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_ARP_TPA;
              fld_rec.value = 64'(field_accumulator_next[31:0]);
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // Transport header, relative to its start offset
      if (l4_on) begin
        if (rel == 7'd1) begin
          fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_SRC_PORT;
          fld_rec.value = 64'(low2); fld_rec.service = ehx_pkg::svc_of(low2);
        end else if (rel == 7'd3) begin
          fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_DST_PORT;
          fld_rec.value = 64'(low2); fld_rec.service = ehx_pkg::svc_of(low2);
        end else if (transport_kind == ehx_pkg::L4_TCP) begin
          case (rel)
            7'd7: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_TCP_SEQ;
              fld_rec.value = 64'(field_accumulator_next[31:0]);
            end
            7'd11: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_TCP_ACK;
              fld_rec.value = 64'(field_accumulator_next[31:0]);
            end
            7'd12: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_TCP_HLEN;
              fld_rec.value = 64'({data_byte[7:4], 2'b00});
            end
            7'd13: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_TCP_FLAGS;
              fld_rec.value = 64'(data_byte);
            end
            7'd15: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_TCP_WINDOW;
              fld_rec.value = 64'(low2);
            end
            7'd17: begin
              fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_TCP_CSUM;
              fld_rec.value = 64'(low2);
            end
            default: ;
          endcase
        end else if (transport_kind == ehx_pkg::L4_UDP) begin
          if (rel == 7'd5) begin
            fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_UDP_LEN;
            fld_rec.value = 64'(low2);
          end else if (rel == 7'd7) begin
            fld_valid = 1'b1; fld_rec.kind = ehx_pkg::K_UDP_CSUM;
            fld_rec.value = 64'(low2);
          end
        end
      end
    end

    // Close the frame on its last byte; otherwise advance, saturating at the top.
    if (last_byte) begin
      byte_offset_next     = '0;
      network_kind_next    = ehx_pkg::NET_OTHER;
      transport_kind_next  = ehx_pkg::L4_NONE;
      transport_start_next = '0;
    end else if (byte_offset != ehx_pkg::OFFSET_MAX) begin
      byte_offset_next = byte_offset + 1'b1;
    end else begin
      byte_offset_next = byte_offset;
    end
  end

  // Frame length record, always after any field record of the same byte
  assign len_rec.kind          = ehx_pkg::K_FRAME_LEN;
  assign len_rec.value         = 64'(byte_offset) + 64'd1;
  assign len_rec.service       = ehx_pkg::SVC_NONE;
  assign len_rec.packet_number = frame_count_next;
  assign len_rec.last          = 1'b1;

  assign push_n  = accept ? (2'(fld_valid) + 2'(last_byte)) : 2'd0;
  assign len_ptr = wr_ptr + ehx_pkg::FIFO_AW'(fld_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= '0;
      field_accumulator <= '0;
      network_kind      <= ehx_pkg::NET_OTHER;
      transport_kind    <= ehx_pkg::L4_NONE;
      transport_start   <= '0;
      frame_count       <= '0;
    end else if (accept) begin
      byte_offset       <= byte_offset_next;
      field_accumulator <= field_accumulator_next;
      network_kind      <= network_kind_next;
      transport_kind    <= transport_kind_next;
      transport_start   <= transport_start_next;
      frame_count       <= frame_count_next;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept && fld_valid) begin
      fifo[wr_ptr] <= fld_rec;
    end
    if (accept && last_byte) begin
      fifo[len_ptr] <= len_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ehx_pkg::FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ehx_pkg::FIFO_CW'(push_n) - ehx_pkg::FIFO_CW'(pop);
    end
  end

  // Present the queue head; it stays put while out_stall holds it.
  assign out_valid     = count != '0;
  assign record_kind   = fifo[rd_ptr].kind;
  assign value         = fifo[rd_ptr].value;
  assign service       = fifo[rd_ptr].service;
  assign packet_number = fifo[rd_ptr].packet_number;
  assign last          = fifo[rd_ptr].last;

endmodule
`default_nettype wire
